// File: rtl/core/czc_pkg.sv
// czc_pkg: shared types, constants and helper functions for the zone classifier
// used by czc_cell and cidr_zone_classifier; no dependencies
package czc_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int COUNT_W         = 5;
    localparam int INDEX_W         = 4;
    localparam int PREFIX_W        = 8;
    localparam int HALF_W          = 64;

    localparam logic [PREFIX_W-1:0] V4_PREFIX_MAX = 8'd32;
    localparam logic [PREFIX_W-1:0] V6_PREFIX_MAX = 8'd128;
    localparam logic [7:0]          LOOPBACK_BYTE = 8'd127;

    typedef enum logic [1:0] {
        FUNC_WR_PERIMETER = 2'd0,
        FUNC_WR_INTERNAL  = 2'd1,
        FUNC_CLASSIFY     = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ZONE_LOCAL     = 2'd0,
        ZONE_PERIMETER = 2'd1,
        ZONE_INTERNAL  = 2'd2,
        ZONE_EXTERNAL  = 2'd3
    } zone_t;

    typedef enum logic [0:0] {
        CFG_PERIMETER_COUNT = 1'b0,
        CFG_INTERNAL_COUNT  = 1'b1
    } cfg_reg_t;

    // item travelling down the cell chain
    typedef struct packed {
        logic               valid;
        func_t              func;
        logic [INDEX_W-1:0] index;
        logic               is_v6;
        logic [HALF_W-1:0]  mask_hi;
        logic [HALF_W-1:0]  mask_lo;
        logic [HALF_W-1:0]  addr_hi;
        logic [HALF_W-1:0]  addr_lo;
        logic               is_local;
        logic               per_hit;
        logic               int_hit;
    } tok_t;

    // saturate the prefix for the family and expand it to a 128-bit mask
    function automatic logic [2*HALF_W-1:0] prefix_mask(
        input logic                v6,
        input logic [PREFIX_W-1:0] prefix
    );
        logic [PREFIX_W-1:0] p;
        logic [2*HALF_W-1:0] m;
        p = prefix;
        if (!v6 && (p > V4_PREFIX_MAX))
        begin
            p = V4_PREFIX_MAX;
        end
        else if (v6 && (p > V6_PREFIX_MAX))
        begin
            p = V6_PREFIX_MAX;
        end
        for (int k = 0; k < 2*HALF_W; k++)
        begin
            m[2*HALF_W-1-k] = (k < int'(p));
        end
        return m;
    endfunction

    function automatic logic entry_match(
        input logic                entry_v6,
        input logic [2*HALF_W-1:0] entry_base,
        input logic [2*HALF_W-1:0] entry_mask,
        input logic                addr_v6,
        input logic [2*HALF_W-1:0] addr
    );
        return (entry_v6 == addr_v6) && (((entry_base ^ addr) & entry_mask) == '0);
    endfunction

endpackage

// File: rtl/core/czc_cell.sv
// czc_cell: one slot of the perimeter and internal tables plus one chain stage
// depends on czc_pkg (tok_t, prefix mask and match helpers)
module czc_cell
    import czc_pkg::*;
#(
    parameter int CELL_IDX = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  tok_t               tok_in,
    input  logic [COUNT_W-1:0] per_count,
    input  logic [COUNT_W-1:0] int_count,
    output tok_t               tok_out
);

    logic                per_v6_reg;
    logic [2*HALF_W-1:0] per_base_reg;
    logic [2*HALF_W-1:0] per_mask_reg;
    logic                int_v6_reg;
    logic [2*HALF_W-1:0] int_base_reg;
    logic [2*HALF_W-1:0] int_mask_reg;

    logic                valid_reg;
    logic                valid_next;
    tok_t                tok_reg;
    tok_t                tok_next;

    logic                slot_sel;
    logic                per_we;
    logic                int_we;
    logic                per_live;
    logic                int_live;
    logic [2*HALF_W-1:0] addr;

    always_comb
    begin
        slot_sel = (int'(tok_in.index) == CELL_IDX);
        per_we   = tok_in.valid && (tok_in.func == FUNC_WR_PERIMETER) && slot_sel;
        int_we   = tok_in.valid && (tok_in.func == FUNC_WR_INTERNAL) && slot_sel;
        // slot takes part only below the programmed count
        per_live = (int'(per_count) > CELL_IDX);
        int_live = (int'(int_count) > CELL_IDX);
        addr     = {tok_in.addr_hi, tok_in.addr_lo};

        valid_next = tok_in.valid;
        tok_next   = tok_in;
        if (tok_in.func == FUNC_CLASSIFY)
        begin
            tok_next.per_hit = tok_in.per_hit | (per_live &&
                entry_match(per_v6_reg, per_base_reg, per_mask_reg, tok_in.is_v6, addr));
            tok_next.int_hit = tok_in.int_hit | (int_live &&
                entry_match(int_v6_reg, int_base_reg, int_mask_reg, tok_in.is_v6, addr));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (per_we)
        begin
            per_v6_reg   <= tok_in.is_v6;
            per_base_reg <= addr;
            per_mask_reg <= {tok_in.mask_hi, tok_in.mask_lo};
        end
        if (int_we)
        begin
            int_v6_reg   <= tok_in.is_v6;
            int_base_reg <= addr;
            int_mask_reg <= {tok_in.mask_hi, tok_in.mask_lo};
        end
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = valid_reg;
    end

endmodule

// File: rtl/core/cidr_zone_classifier.sv
// cidr_zone_classifier: address zone lookup over a chain of table cells
// depends on czc_pkg and czc_cell
// a classify item gives its zone strobe once it has passed the registered cell of every table slot
// throughput: one item per cycle, set by one cell stage per table slot; busy stays low
// writes travel down the same chain, so later items always see earlier writes
// reset clears the counts and the chain valid bits; table slots hold junk until written
module cidr_zone_classifier
    import czc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          func,
    input  logic [INDEX_W-1:0]  index,
    input  logic                is_v6,
    input  logic [PREFIX_W-1:0] prefix_len,
    input  logic [HALF_W-1:0]   addr_hi,
    input  logic [HALF_W-1:0]   addr_lo,
    output logic                done,
    output logic [1:0]          zone,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [COUNT_W-1:0]  cfg_data
);

    logic [COUNT_W-1:0] perimeter_count_reg;
    logic [COUNT_W-1:0] perimeter_count_next;
    logic [COUNT_W-1:0] internal_count_reg;
    logic [COUNT_W-1:0] internal_count_next;

    tok_t               chain [TABLE_DEPTH+1];
    tok_t               in_tok;
    tok_t               last_tok;
    logic               func_known;
    logic [2*HALF_W-1:0] mask;

    assign busy = 1'b0;

    always_comb
    begin
        perimeter_count_next = perimeter_count_reg;
        internal_count_next  = internal_count_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_PERIMETER_COUNT: perimeter_count_next = cfg_data;
                CFG_INTERNAL_COUNT:  internal_count_next  = cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perimeter_count_reg <= '0;
            internal_count_reg  <= '0;
        end
        else
        begin
            perimeter_count_reg <= perimeter_count_next;
            internal_count_reg  <= internal_count_next;
        end
    end

    always_comb
    begin
        case (func_t'(func))
            FUNC_WR_PERIMETER: func_known = 1'b1;
            FUNC_WR_INTERNAL:  func_known = 1'b1;
            FUNC_CLASSIFY:     func_known = 1'b1;
            default:           func_known = 1'b0;
        endcase
        mask = prefix_mask(is_v6, prefix_len);

        in_tok.valid    = start && !busy && func_known;
        in_tok.func     = func_t'(func);
        in_tok.index    = index;
        in_tok.is_v6    = is_v6;
        in_tok.mask_hi  = mask[2*HALF_W-1:HALF_W];
        in_tok.mask_lo  = mask[HALF_W-1:0];
        in_tok.addr_hi  = addr_hi;
        in_tok.addr_lo  = addr_lo;
        // loopback: 127/8 for ipv4, ::1 for ipv6
        in_tok.is_local = is_v6 ? ((addr_hi == '0) && (addr_lo == HALF_W'(1)))
                                : (addr_hi[HALF_W-1:HALF_W-8] == LOOPBACK_BYTE);
        in_tok.per_hit  = 1'b0;
        in_tok.int_hit  = 1'b0;
    end

    assign chain[0] = in_tok;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        czc_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .tok_in    (chain[g]),
            .per_count (perimeter_count_reg),
            .int_count (internal_count_reg),
            .tok_out   (chain[g+1])
        );
    end

    assign last_tok = chain[TABLE_DEPTH];

    always_comb
    begin
        done = last_tok.valid && (last_tok.func == FUNC_CLASSIFY);
        if (last_tok.is_local)
        begin
            zone = ZONE_LOCAL;
        end
        else if (last_tok.per_hit)
        begin
            zone = ZONE_PERIMETER;
        end
        else if (last_tok.int_hit)
        begin
            zone = ZONE_INTERNAL;
        end
        else
        begin
            zone = ZONE_EXTERNAL;
        end
    end

endmodule
